// ===== design/bgn_pkg.sv =====
// Shared constants, types and helpers of the binary grid neighbour counter.
package bgn_pkg;

	localparam int MAX_WIDTH_DEF = 32;

	localparam int GRID_WIDTH_W = 6;
	localparam int ROW_W        = 10;
	localparam int OUT_COL_W    = 5;
	localparam int COUNT_W      = 4;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 10;

	localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'd1;

	localparam logic [GRID_WIDTH_W-1:0] GRID_WIDTH_RST  = 6'd26;
	localparam logic [ROW_W-1:0]        GRID_HEIGHT_RST = 10'd10;

	// one window column: [0] current row, [1] row above, [2] two rows above
	typedef logic [2:0] colv_t;
	// line memory word: [0] most recent row, [1] the row before it
	typedef logic [1:0] memw_t;

	typedef struct packed {
		logic [GRID_WIDTH_W-1:0] last_col;
		logic [ROW_W-1:0]        last_row;
	} cfg_t;

	typedef struct packed {
		logic [ROW_W-1:0]        pos_row;
		logic [GRID_WIDTH_W-1:0] pos_col;
		logic [ROW_W-1:0]        row;
		logic [GRID_WIDTH_W-1:0] col;
		colv_t                   win0;
		colv_t                   win1;
		colv_t                   win2;
		memw_t                   rd;
	} scan_t;

	typedef struct packed {
		logic                    drain;
		logic                    fire;
		logic [GRID_WIDTH_W-1:0] col;
	} rd_ctl_t;

	typedef struct packed {
		logic                 centre;
		logic [COUNT_W-1:0]   count;
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
		logic                 last;
	} res_t;

	function automatic logic [COUNT_W-1:0] count_set(input logic [7:0] bits);
		logic [COUNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) n = n + COUNT_W'(bits[i]);
		return n;
	endfunction

endpackage

// ===== design/bgn_if.sv =====
// Valid/ready stream interfaces for grid cells and neighbour count results.
interface bgn_cell_if;
	logic valid;
	logic ready;
	logic cell_bit;

	modport source (output valid, output cell_bit, input ready);
	modport sink (input valid, input cell_bit, output ready);
endinterface

interface bgn_result_if;
	logic                          valid;
	logic                          ready;
	logic                          centre_bit;
	logic [bgn_pkg::COUNT_W-1:0]   neighbour_count;
	logic [bgn_pkg::ROW_W-1:0]     cell_row;
	logic [bgn_pkg::OUT_COL_W-1:0] cell_column;
	logic                          frame_last;

	modport source (output valid, output centre_bit, output neighbour_count,
		output cell_row, output cell_column, output frame_last, input ready);
	modport sink (input valid, input centre_bit, input neighbour_count,
		input cell_row, input cell_column, input frame_last, output ready);
endinterface

// ===== design/bgn_cfg.sv =====
// Grid size registers and the clamped last column and last row derived from them.
module bgn_cfg #(
	parameter int MAX_WIDTH = bgn_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [bgn_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bgn_pkg::CFG_DATA_W-1:0]   cfg_data,
	output bgn_pkg::cfg_t                    cfg,
	output logic                             restart
);
	import bgn_pkg::*;

	localparam logic [GRID_WIDTH_W-1:0] MAXW = GRID_WIDTH_W'(MAX_WIDTH);

	logic [GRID_WIDTH_W-1:0] width_q;
	logic [ROW_W-1:0]        height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= GRID_WIDTH_RST;
			height_q <= GRID_HEIGHT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_GRID_WIDTH:  width_q  <= cfg_data[GRID_WIDTH_W-1:0];
				REG_GRID_HEIGHT: height_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// any known register write restarts the frame
	assign restart = cfg_write &&
		(cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

	always_comb begin
		if (width_q == '0)
			cfg.last_col = '0;
		else if (width_q > MAXW)
			cfg.last_col = MAXW - GRID_WIDTH_W'(1);
		else
			cfg.last_col = width_q - GRID_WIDTH_W'(1);
		cfg.last_row = (height_q == '0) ? '0 : height_q - ROW_W'(1);
	end

endmodule

// ===== design/bgn_line_mem.sv =====
// Line memory: one word per column holding the two most recent rows.
module bgn_line_mem #(
	parameter int DEPTH = bgn_pkg::MAX_WIDTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  bgn_pkg::memw_t wdata,
	input  logic           re,
	input  logic [AW-1:0]  raddr,
	output bgn_pkg::memw_t rdata_q
);
	import bgn_pkg::*;

	memw_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

endmodule

// ===== design/bgn_scan.sv =====
// Raster position counters, line memory access and the 3x3 column window.
module bgn_scan #(
	parameter int MAX_WIDTH = bgn_pkg::MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bgn_pkg::cfg_t    cfg,
	input  logic             restart,
	input  logic             accept,
	input  logic             cell_bit,
	input  bgn_pkg::rd_ctl_t rd_ctl,
	output bgn_pkg::scan_t   scan
);
	import bgn_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [CW-1:0]    col_q, next_col, raddr;
	logic [ROW_W-1:0] row_q;
	logic             at_last_col;
	logic             re;
	memw_t            wdata, rdata, rd_eff, byp_data_q;
	logic             byp_q;
	colv_t            win0_s1, win1_s1, win2_s1;
	logic [ROW_W-1:0] row_s1;
	logic [CW-1:0]    col_s1;

	assign at_last_col = (col_q == cfg.last_col[CW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (at_last_col) begin
				col_q <= '0;
				row_q <= (row_q == cfg.last_row) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// prefetch the column of the next item so its word is ready when it arrives
	always_comb begin
		if (restart)
			next_col = '0;
		else if (accept)
			next_col = at_last_col ? '0 : col_q + CW'(1);
		else
			next_col = col_q;
	end

	// an item taken on the last drain step still prefetches its next column
	assign raddr = rd_ctl.fire ? rd_ctl.col[CW-1:0] : next_col;
	assign re    = rd_ctl.drain ? (rd_ctl.fire || accept) : 1'b1;
	assign wdata = {rd_eff[0], cell_bit};

	bgn_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_mem (
		.clk     (clk),
		.we      (accept),
		.waddr   (col_q),
		.wdata   (wdata),
		.re      (re),
		.raddr   (raddr),
		.rdata_q (rdata)
	);

	// one-column grid: the word written now is the one read next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (re) begin
			byp_q <= accept && (col_q == raddr);
		end
	end

	always_ff @(posedge clk) begin
		if (re) byp_data_q <= wdata;
	end

	assign rd_eff = byp_q ? byp_data_q : rdata;

	always_ff @(posedge clk) begin
		if (accept) begin
			win0_s1 <= {rd_eff[1], rd_eff[0], cell_bit};
			win1_s1 <= win0_s1;
			win2_s1 <= win1_s1;
			row_s1  <= row_q;
			col_s1  <= col_q;
		end
	end

	always_comb begin
		scan.pos_row = row_q;
		scan.pos_col = GRID_WIDTH_W'(col_q);
		scan.row     = row_s1;
		scan.col     = GRID_WIDTH_W'(col_s1);
		scan.win0    = win0_s1;
		scan.win1    = win1_s1;
		scan.win2    = win2_s1;
		scan.rd      = rd_eff;
	end

endmodule

// ===== design/bgn_emit.sv =====
// Result sequencer: window results, row end result, final row drain, output register.
module bgn_emit #(
	parameter int MAX_WIDTH = bgn_pkg::MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bgn_pkg::cfg_t     cfg,
	input  bgn_pkg::scan_t    scan,
	input  logic              accept,
	output logic              in_ready,
	output bgn_pkg::rd_ctl_t  rd_ctl,
	bgn_result_if.source      results
);
	import bgn_pkg::*;

	localparam int DSW = $clog2(MAX_WIDTH + 2);
	localparam int XW  = GRID_WIDTH_W + 1;

	logic                    main_q, end_q, drain_q;
	logic                    main_n, end_n, drain_n;
	logic [DSW-1:0]          ds_q;
	memw_t                   dw0_q, dw1_q;
	logic                    out_valid_s2;
	res_t                    res_s2;
	logic                    out_free, emit_main, emit_end;
	logic                    drain_act, drain_emit, step_fire, drain_done;
	logic [XW-1:0]           ds_x, lc1;
	logic                    up, upd, lv_m, lv_e, lv_d, rv_d;
	logic                    a_row_nz, a_end;
	logic [GRID_WIDTH_W-1:0] col_m, col_d;
	logic [ROW_W-1:0]        row_m;
	res_t                    res_main, res_end, res_drain, res_n;

	assign out_free  = !out_valid_s2 || results.ready;
	assign emit_main = main_q && out_free;
	assign emit_end  = !main_q && end_q && out_free;
	assign drain_act = !main_q && !end_q && drain_q;

	// drain step s reads column s, emits column s-2 once its right neighbour is in
	assign ds_x       = XW'(ds_q);
	assign lc1        = XW'(cfg.last_col) + XW'(1);
	assign drain_emit = ds_x >= XW'(2);
	assign step_fire  = drain_act && (!drain_emit || out_free);
	assign drain_done = step_fire && (ds_x == lc1 + XW'(1));

	assign main_n  = main_q && !emit_main;
	assign end_n   = end_q && !emit_end;
	assign drain_n = drain_q && !drain_done;
	assign in_ready = !main_n && !end_n && !drain_n;

	assign rd_ctl.drain = drain_act;
	assign rd_ctl.fire  = step_fire && (ds_x <= XW'(cfg.last_col));
	assign rd_ctl.col   = GRID_WIDTH_W'(ds_q);

	assign a_row_nz = (scan.pos_row != '0);
	assign a_end    = (scan.pos_col == cfg.last_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_q  <= 1'b0;
			end_q   <= 1'b0;
			drain_q <= 1'b0;
			ds_q    <= '0;
		end else begin
			if (accept) begin
				main_q  <= a_row_nz && (scan.pos_col != '0);
				end_q   <= a_row_nz && a_end;
				drain_q <= (scan.pos_row == cfg.last_row) && a_end;
			end else begin
				main_q  <= main_n;
				end_q   <= end_n;
				drain_q <= drain_n;
			end
			if (step_fire) ds_q <= drain_done ? '0 : ds_q + DSW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			dw1_q <= dw0_q;
			dw0_q <= scan.rd;
		end
	end

	// edge masks: row above and row two above exist, left column exists, right column exists
	assign up   = scan.row > ROW_W'(1);
	assign upd  = scan.row != '0;
	assign lv_m = scan.col > GRID_WIDTH_W'(1);
	assign lv_e = scan.col != '0;
	assign lv_d = ds_x >= XW'(3);
	assign rv_d = ds_x <= lc1;

	assign row_m = scan.row - ROW_W'(1);
	assign col_m = scan.col - GRID_WIDTH_W'(1);
	assign col_d = GRID_WIDTH_W'(ds_q) - GRID_WIDTH_W'(2);

	always_comb begin
		res_main.centre = scan.win1[1];
		res_main.count  = count_set({
			scan.win0[0], scan.win0[1], scan.win0[2] & up,
			scan.win1[0], scan.win1[2] & up,
			scan.win2[0] & lv_m, scan.win2[1] & lv_m, scan.win2[2] & lv_m & up});
		res_main.row    = row_m;
		res_main.col    = col_m[OUT_COL_W-1:0];
		res_main.last   = 1'b0;

		res_end.centre = scan.win0[1];
		res_end.count  = count_set({
			scan.win0[0], scan.win0[2] & up,
			scan.win1[0] & lv_e, scan.win1[1] & lv_e, scan.win1[2] & lv_e & up,
			3'b000});
		res_end.row    = row_m;
		res_end.col    = scan.col[OUT_COL_W-1:0];
		res_end.last   = 1'b0;

		res_drain.centre = dw0_q[0];
		res_drain.count  = count_set({
			dw0_q[1] & upd,
			dw1_q[0] & lv_d, dw1_q[1] & lv_d & upd,
			scan.rd[0] & rv_d, scan.rd[1] & rv_d & upd,
			3'b000});
		res_drain.row    = scan.row;
		res_drain.col    = col_d[OUT_COL_W-1:0];
		res_drain.last   = drain_done;

		if (main_q)
			res_n = res_main;
		else if (end_q)
			res_n = res_end;
		else
			res_n = res_drain;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= emit_main || emit_end || (step_fire && drain_emit);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) res_s2 <= res_n;
	end

	assign results.valid           = out_valid_s2;
	assign results.centre_bit      = res_s2.centre;
	assign results.neighbour_count = res_s2.count;
	assign results.cell_row        = res_s2.row;
	assign results.cell_column     = res_s2.col;
	assign results.frame_last      = res_s2.last;

endmodule

// ===== design/binary_grid_neighbour_count_core.sv =====
// Streaming 3x3 neighbour counter over a binary grid given one cell per item in raster
// order. Each cell comes back with its own bit and the number of its eight neighbours
// that are set (cells outside the grid count as zero), one row and one column late.
// Most cells go straight through: an item is accepted every clock while the output
// keeps up. The last cell of a row below the first also releases the row-end cell
// above, and the next item waits until that result is out. The last cell of the frame
// gives its own results, then the final row is read back from the line memory and
// released one column per cycle while the output keeps up, the last result flagged
// with frame_last; the next item can be taken on the final read-back step. No clearing
// pass is needed after reset. A write to either grid size register restarts the frame.
module binary_grid_neighbour_count_core #(
	parameter int MAX_WIDTH = bgn_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [bgn_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bgn_pkg::CFG_DATA_W-1:0]  cfg_data,
	bgn_cell_if.sink                        cells,
	bgn_result_if.source                    results
);
	import bgn_pkg::*;

	cfg_t    cfg;
	scan_t   scan;
	rd_ctl_t rd_ctl;
	logic    restart;
	logic    in_ready;
	logic    accept;

	assign cells.ready = in_ready;
	assign accept      = cells.valid && in_ready;

	bgn_cfg #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.restart   (restart)
	);

	bgn_scan #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.restart  (restart),
		.accept   (accept),
		.cell_bit (cells.cell_bit),
		.rd_ctl   (rd_ctl),
		.scan     (scan)
	);

	bgn_emit #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.scan     (scan),
		.accept   (accept),
		.in_ready (in_ready),
		.rd_ctl   (rd_ctl),
		.results  (results)
	);

	// the line memory must not be written while the final row is read back
	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ctl.fire |-> !accept)
		else $error("item accepted during final row read-back");

	a_restart_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> (scan.pos_col == '0 && scan.pos_row == '0))
		else $error("frame position not cleared by a size write");

	a_last_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.frame_last) |->
			(results.cell_column == cfg.last_col[OUT_COL_W-1:0]))
		else $error("frame_last away from the last column");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.neighbour_count <= COUNT_W'(8)))
		else $error("neighbour count above eight");

endmodule
